// File: rtl/gis_pkg.sv
// Shared constants, queue entry type and fixed-point helper for the interval subdivider.
`timescale 1ns / 1ps

package gis_pkg;

    localparam int COORD_W      = 32;
    localparam int COUNT_W      = 6;
    localparam int RATIO_W      = 32;
    localparam int THR_W        = 16;
    localparam int MAX_SEGMENTS = 63;

    // Extra fraction bits carried below the coordinate LSB by step and accumulator
    localparam int STEP_XBITS = 16;
    localparam int ACC_W      = COORD_W + STEP_XBITS;
    // Quotient width: |span| <= 2^32 and sum >= 1.0, so the step stays below 2^49
    localparam int QUO_W      = 49;
    // Increment width: increments saturate at 2^50
    localparam int INC_W      = 51;
    localparam int SUM_W      = INC_W + 1;
    // Ratio powers saturate at 2^62
    localparam int POW_W      = 63;
    localparam int REM_W      = 63;
    // Low magnitude bits still to be shifted in once the divide starts
    localparam int DIV_PRE    = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;
    localparam logic [63:0] POW_CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] SUM_CAP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INC_CAP = 64'h0004_0000_0000_0000;

    localparam logic signed [SUM_W-1:0] ACC_MIN = 52'shF_8000_0000_0000;
    localparam logic signed [SUM_W-1:0] ACC_MAX = 52'sh0_7FFF_FFFF_0000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 48'sh0000_0000_8000;

    // One classified interval, handed from the front end to the node generator
    typedef struct packed {
        logic signed [COORD_W-1:0] left_coord;
        logic signed [COORD_W-1:0] right_coord;
        logic [COUNT_W-1:0]        count;
        logic [RATIO_W-1:0]        ratio;
        logic                      uniform;
        logic                      neg;
        logic [QUO_W-1:0]          inc;
    } job_t;

    // floor(a * r / 2^30) from the two partial products of a split a, saturated at cap
    function automatic logic [63:0] q30_join(input logic [63:0] hi_prod,
                                             input logic [63:0] lo_prod,
                                             input logic [63:0] cap);
        logic [65:0] total;
        total = {hi_prod, 2'b00} + {32'd0, lo_prod[63:30]};
        return (total > {2'b00, cap}) ? cap : total[63:0];
    endfunction

endpackage

// File: rtl/gis_if.sv
// Valid/ready channel interfaces for intervals in and nodes out.
`timescale 1ns / 1ps

interface gis_in_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [gis_pkg::COORD_W-1:0]          left_coord;
    logic signed [gis_pkg::COORD_W-1:0]          right_coord;
    logic [gis_pkg::COUNT_W-1:0]                 segment_count;
    logic [gis_pkg::RATIO_W-1:0]                 growth_ratio;

    modport source (output valid, output left_coord, output right_coord,
                    output segment_count, output growth_ratio, input ready);
    modport sink   (input valid, input left_coord, input right_coord,
                    input segment_count, input growth_ratio, output ready);
endinterface

interface gis_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [gis_pkg::COORD_W-1:0] node_coord;
    logic [gis_pkg::COUNT_W-1:0]        node_index;
    logic                               last_node;

    modport source (output valid, output node_coord, output node_index,
                    output last_node, input ready);
    modport sink   (input valid, input node_coord, input node_index,
                    input last_node, output ready);
endinterface

// File: rtl/graded_interval_subdivider_top.sv
// Top level of the graded interval subdivider: threshold register, front end, queue, node generator.
`timescale 1ns / 1ps

// Splits each accepted interval [left_coord, right_coord] into segment_count pieces (a
// count of zero is taken as one) whose lengths grow by growth_ratio (Q2.30; one or below
// gives uniform spacing) and emits one node item more than pieces, index 0 being
// left_coord and the last, flagged by last_node, being exactly right_coord. The front
// end accepts one interval and holds ready low while it works: it captures the
// interval, sums the ratio powers on a split 32x32 multiply in two passes per power (one
// pass when the ratio is one or below), runs a restoring divide of the span by that sum
// and hands the job to a two-entry queue, waiting there for a free entry if need be;
// while the node side keeps up, this loop sets the sustained rate. The node generator
// drains the queue on its own: one node per cycle with uniform spacing while its output
// register is free or being read, otherwise each node but the last is followed by an
// increment update (the increment is regrown by a split multiply). Its output register
// holds a node until it is taken, and the next node waits until then.
// step_zero_threshold is written through cfg_we / cfg_wdata; write it only while no
// interval is in flight. Nodes saturate at the Q16.16 coordinate range.

module graded_interval_subdivider_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [gis_pkg::THR_W-1:0] cfg_wdata,
    gis_in_if.sink                    interval,
    gis_out_if.source                 nodes
);

    // Step magnitudes below this unsigned Q16.0 value, in coordinate LSBs, are dropped to zero
    logic [gis_pkg::THR_W-1:0] thr_reg;

    // Front end to queue
    logic          push_valid;
    logic          push_ready;
    gis_pkg::job_t push_job;

    // Queue to node generator
    logic          pop_valid;
    logic          pop_ready;
    gis_pkg::job_t pop_job;

    // Hold the threshold until the next write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Accept and classify: powers, divide, threshold
    gis_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .thr        (thr_reg),
        .interval   (interval),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Decouple the front end from the node generator
    gis_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Walk the nodes of one job at a time
    gis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .nodes     (nodes)
    );

endmodule

// File: rtl/gis_front.sv
// Front end: accept an interval, sum the ratio powers, divide the span, push a job.
`timescale 1ns / 1ps

module gis_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gis_pkg::THR_W-1:0]   thr,
    gis_in_if.sink                      interval,
    output logic                        push_valid,
    input  logic                        push_ready,
    output gis_pkg::job_t               push_job
);

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_POW_LO = 5'b00010,
        F_POW_HI = 5'b00100,
        F_DIV    = 5'b01000,
        F_PUSH   = 5'b10000
    } f_state_t;

    f_state_t f_state_reg, f_state_next;

    logic signed [gis_pkg::COORD_W-1:0] left_reg, right_reg;
    logic [gis_pkg::COUNT_W-1:0]        n_reg, k_reg, cnt_reg;
    logic [gis_pkg::RATIO_W-1:0]        ratio_reg;
    logic                               uniform_reg;
    logic signed [gis_pkg::COORD_W:0]   span_reg;
    logic [gis_pkg::POW_W-1:0]          p_reg;
    logic [63:0]                        s_reg;
    logic [63:0]                        lo_prod_reg;
    logic [gis_pkg::REM_W-1:0]          rem_reg;
    logic [gis_pkg::QUO_W-1:0]          quo_reg;
    logic [gis_pkg::DIV_PRE-1:0]        dbits_reg;

    logic [gis_pkg::COUNT_W-1:0]        n_clamped;
    logic                               uniform_in;
    logic [gis_pkg::RATIO_W-1:0]        ratio_clamped;
    logic [64:0]                        s_sum;
    logic [63:0]                        s_next;
    logic                               pow_last;
    logic [gis_pkg::COORD_W:0]          mag;
    logic [63:0]                        trial;
    logic                               trial_ge;
    logic [gis_pkg::QUO_W-1:0]          thr_ext;
    logic                               accept;

    assign interval.ready = (f_state_reg == F_IDLE);
    assign accept         = interval.valid && (f_state_reg == F_IDLE);

    always_comb
    begin
        if (interval.segment_count == '0)
        begin
            n_clamped = 6'd1;
        end
        else if (interval.segment_count > 6'(gis_pkg::MAX_SEGMENTS))
        begin
            n_clamped = 6'(gis_pkg::MAX_SEGMENTS);
        end
        else
        begin
            n_clamped = interval.segment_count;
        end
        uniform_in    = (interval.growth_ratio <= gis_pkg::Q30_ONE[31:0]);
        ratio_clamped = uniform_in ? gis_pkg::Q30_ONE[31:0] : interval.growth_ratio;

        s_sum    = {1'b0, s_reg} + {2'b00, p_reg};
        s_next   = (s_sum > {1'b0, gis_pkg::SUM_CAP}) ? gis_pkg::SUM_CAP : s_sum[63:0];
        pow_last = (k_reg == (n_reg - 6'd1));
        mag      = span_reg[gis_pkg::COORD_W] ? 33'(-span_reg) : 33'(span_reg);

        trial    = {rem_reg, dbits_reg[gis_pkg::DIV_PRE-1]};
        trial_ge = (trial >= s_reg);

        thr_ext  = {{(gis_pkg::QUO_W - gis_pkg::THR_W - gis_pkg::STEP_XBITS){1'b0}},
                    thr, {gis_pkg::STEP_XBITS{1'b0}}};
    end

    always_comb
    begin
        f_state_next = f_state_reg;
        case (f_state_reg)
            F_IDLE:
            begin
                if (interval.valid)
                begin
                    f_state_next = F_POW_LO;
                end
            end
            F_POW_LO:
            begin
                if (pow_last)
                begin
                    f_state_next = F_DIV;
                end
                else if (!uniform_reg)
                begin
                    f_state_next = F_POW_HI;
                end
            end
            F_POW_HI:
            begin
                f_state_next = F_POW_LO;
            end
            F_DIV:
            begin
                if (cnt_reg == 6'(gis_pkg::QUO_W - 1))
                begin
                    f_state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    f_state_next = F_IDLE;
                end
            end
            default:
            begin
                f_state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_state_reg <= F_IDLE;
        end
        else
        begin
            f_state_reg <= f_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (f_state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    left_reg    <= interval.left_coord;
                    right_reg   <= interval.right_coord;
                    n_reg       <= n_clamped;
                    ratio_reg   <= ratio_clamped;
                    uniform_reg <= uniform_in;
                    span_reg    <= {interval.right_coord[31], interval.right_coord}
                                 - {interval.left_coord[31], interval.left_coord};
                    p_reg       <= gis_pkg::Q30_ONE[gis_pkg::POW_W-1:0];
                    s_reg       <= '0;
                    k_reg       <= '0;
                end
            end
            F_POW_LO:
            begin
                s_reg       <= s_next;
                lo_prod_reg <= {32'd0, p_reg[31:0]} * {32'd0, ratio_reg};
                if (pow_last)
                begin
                    rem_reg   <= {33'd0, mag[gis_pkg::COORD_W:gis_pkg::DIV_PRE]};
                    dbits_reg <= mag[gis_pkg::DIV_PRE-1:0];
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                end
                else if (uniform_reg)
                begin
                    k_reg <= k_reg + 6'd1;
                end
            end
            F_POW_HI:
            begin
                p_reg <= gis_pkg::POW_W'(gis_pkg::q30_join(
                             {33'd0, p_reg[62:32]} * {32'd0, ratio_reg},
                             lo_prod_reg,
                             gis_pkg::POW_CAP));
                k_reg <= k_reg + 6'd1;
            end
            F_DIV:
            begin
                rem_reg   <= trial_ge ? 63'(trial - s_reg) : trial[gis_pkg::REM_W-1:0];
                quo_reg   <= {quo_reg[gis_pkg::QUO_W-2:0], trial_ge};
                dbits_reg <= {dbits_reg[gis_pkg::DIV_PRE-2:0], 1'b0};
                cnt_reg   <= cnt_reg + 6'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push_valid           = (f_state_reg == F_PUSH);
        push_job.left_coord  = left_reg;
        push_job.right_coord = right_reg;
        push_job.count       = n_reg;
        push_job.ratio       = ratio_reg;
        push_job.uniform     = uniform_reg;
        push_job.neg         = span_reg[gis_pkg::COORD_W];
        push_job.inc         = (quo_reg < thr_ext) ? '0 : quo_reg;
    end

    // Restoring divide keeps the partial remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (f_state_reg == F_DIV) |-> ({1'b0, rem_reg} < s_reg))
        else $error("divide remainder reached the power sum");

    // The power sum always holds at least the leading 1.0 term before the divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (f_state_reg == F_DIV) |-> (s_reg >= gis_pkg::Q30_ONE))
        else $error("power sum below one at divide");

endmodule

// File: rtl/gis_queue.sv
// Two-entry job queue between the front end and the node generator.
`timescale 1ns / 1ps

module gis_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  gis_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output gis_pkg::job_t pop_job
);

    gis_pkg::job_t               entry_reg [gis_pkg::QUEUE_DEPTH];
    logic [gis_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [gis_pkg::QPTR_W:0]    count_reg;
    logic                        do_push, do_pop;

    assign push_ready = (count_reg != (gis_pkg::QPTR_W + 1)'(gis_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [gis_pkg::QPTR_W-1:0] ptr_inc(input logic [gis_pkg::QPTR_W-1:0] p);
        return (p == gis_pkg::QPTR_W'(gis_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Occupancy never exceeds the entries present
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (gis_pkg::QPTR_W + 1)'(gis_pkg::QUEUE_DEPTH))
        else $error("queue occupancy overflow");

endmodule

// File: rtl/gis_back.sv
// Node generator: walk the accumulator, round each node, grow the increment by the ratio.
`timescale 1ns / 1ps

module gis_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  gis_pkg::job_t pop_job,
    gis_out_if.source     nodes
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_EMIT = 3'b010,
        B_MUL  = 3'b100
    } b_state_t;

    b_state_t b_state_reg, b_state_next;

    logic signed [gis_pkg::ACC_W-1:0]   acc_reg;
    logic [gis_pkg::INC_W-1:0]          inc_reg;
    logic [gis_pkg::RATIO_W-1:0]        ratio_reg;
    logic                               uniform_reg;
    logic                               neg_reg;
    logic [gis_pkg::COUNT_W-1:0]        n_reg, idx_reg;
    logic signed [gis_pkg::COORD_W-1:0] right_reg;
    logic [63:0]                        lo_prod_reg;

    logic                               out_valid_reg;
    logic signed [gis_pkg::COORD_W-1:0] out_coord_reg;
    logic [gis_pkg::COUNT_W-1:0]        out_index_reg;
    logic                               out_last_reg;

    logic                               slot_free, at_end, emit_fire, load;
    logic signed [gis_pkg::SUM_W-1:0]   acc_ext, inc_ext, acc_sum;
    logic signed [gis_pkg::ACC_W-1:0]   acc_step, acc_rnd;

    always_comb
    begin
        slot_free = !out_valid_reg || nodes.ready;
        at_end    = (idx_reg == n_reg);
        emit_fire = (b_state_reg == B_EMIT) && slot_free;
        load      = pop_valid && ((b_state_reg == B_IDLE) || (emit_fire && at_end));
        pop_ready = load;

        acc_ext = {{(gis_pkg::SUM_W - gis_pkg::ACC_W){acc_reg[gis_pkg::ACC_W-1]}}, acc_reg};
        inc_ext = {1'b0, inc_reg};
        acc_sum = neg_reg ? (acc_ext - inc_ext) : (acc_ext + inc_ext);
        if (acc_sum < gis_pkg::ACC_MIN)
        begin
            acc_step = gis_pkg::ACC_MIN[gis_pkg::ACC_W-1:0];
        end
        else if (acc_sum > gis_pkg::ACC_MAX)
        begin
            acc_step = gis_pkg::ACC_MAX[gis_pkg::ACC_W-1:0];
        end
        else
        begin
            acc_step = acc_sum[gis_pkg::ACC_W-1:0];
        end
        acc_rnd = acc_reg + gis_pkg::ROUND_HALF;
    end

    always_comb
    begin
        b_state_next = b_state_reg;
        case (b_state_reg)
            B_IDLE:
            begin
                if (load)
                begin
                    b_state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (emit_fire)
                begin
                    if (at_end)
                    begin
                        b_state_next = load ? B_EMIT : B_IDLE;
                    end
                    else if (!uniform_reg)
                    begin
                        b_state_next = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                b_state_next = B_EMIT;
            end
            default:
            begin
                b_state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_state_reg   <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_state_reg <= b_state_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (nodes.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_coord_reg <= at_end ? right_reg
                                    : acc_rnd[gis_pkg::ACC_W-1:gis_pkg::STEP_XBITS];
            out_index_reg <= idx_reg;
            out_last_reg  <= at_end;
        end

        if (load)
        begin
            acc_reg     <= {pop_job.left_coord, {gis_pkg::STEP_XBITS{1'b0}}};
            inc_reg     <= {{(gis_pkg::INC_W - gis_pkg::QUO_W){1'b0}}, pop_job.inc};
            ratio_reg   <= pop_job.ratio;
            uniform_reg <= pop_job.uniform;
            neg_reg     <= pop_job.neg;
            n_reg       <= pop_job.count;
            right_reg   <= pop_job.right_coord;
            idx_reg     <= '0;
        end
        else if (emit_fire && !at_end)
        begin
            acc_reg     <= acc_step;
            idx_reg     <= idx_reg + 6'd1;
            lo_prod_reg <= {32'd0, inc_reg[31:0]} * {32'd0, ratio_reg};
        end
        else if (b_state_reg == B_MUL)
        begin
            inc_reg <= gis_pkg::INC_W'(gis_pkg::q30_join(
                           {45'd0, inc_reg[50:32]} * {32'd0, ratio_reg},
                           lo_prod_reg,
                           gis_pkg::INC_CAP));
        end
    end

    assign nodes.valid      = out_valid_reg;
    assign nodes.node_coord = out_coord_reg;
    assign nodes.node_index = out_index_reg;
    assign nodes.last_node  = out_last_reg;

    // The node counter never runs past the segment count of the job in hand
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_state_reg != B_IDLE) |-> (idx_reg <= n_reg))
        else $error("node index past segment count");

    // An increment update always hands straight back to node emission
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_state_reg == B_MUL) |=> (b_state_reg == B_EMIT))
        else $error("increment update did not return to emit");

endmodule

// File: sim/gis_node_checker.sv
// Node checker for the graded interval subdivider: predicts node items and compares them.
`timescale 1ns / 1ps

module gis_node_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gis_pkg::THR_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [gis_pkg::COORD_W-1:0] left_coord,
    input  logic signed [gis_pkg::COORD_W-1:0] right_coord,
    input  logic [gis_pkg::COUNT_W-1:0]        segment_count,
    input  logic [gis_pkg::RATIO_W-1:0]        growth_ratio,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [gis_pkg::COORD_W-1:0] node_coord,
    input  logic [gis_pkg::COUNT_W-1:0]        node_index,
    input  logic                               last_node,
    output int                                 fail_count,
    output int                                 nodes_owed
);

    localparam int          FRAC_X    = 16;
    localparam logic [63:0] RATIO_ONE = 64'h0000_0000_4000_0000;
    localparam logic [63:0] POWER_MAX = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TOTAL_MAX = 64'h8000_0000_0000_0000;
    localparam logic [63:0] STEP_MAX  = 64'h0004_0000_0000_0000;
    localparam logic signed [63:0] POS_LO = -(64'sd2147483648 <<< FRAC_X);
    localparam logic signed [63:0] POS_HI = 64'sd2147483647 <<< FRAC_X;

    typedef struct packed {
        logic signed [gis_pkg::COORD_W-1:0] coord;
        logic [gis_pkg::COUNT_W-1:0]        index;
        logic                               last;
    } node_t;

    node_t                     expected_nodes[$];
    logic [gis_pkg::THR_W-1:0] zero_thr;
    int                        mismatches = 0;
    int                        owed = 0;

    assign fail_count = mismatches;
    assign nodes_owed = owed;

    task automatic report(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    // floor(a * r / 2^30), held at cap
    function automatic logic [63:0] grow(input logic [63:0] a, input logic [63:0] r,
                                         input logic [63:0] cap);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, r}) >> 30;
        return (prod > {64'd0, cap}) ? cap : prod[63:0];
    endfunction

    task automatic plan_nodes(input logic signed [31:0] lft, input logic signed [31:0] rgt,
                              input logic [5:0] cnt, input logic [31:0] ratio_in);
        logic [63:0]        r;
        logic [63:0]        pw;
        logic [63:0]        total;
        logic [64:0]        total_wide;
        logic [63:0]        step;
        logic [63:0]        mag;
        logic [127:0]       quot;
        logic signed [63:0] l64;
        logic signed [63:0] r64;
        logic signed [63:0] span;
        logic signed [63:0] pos;
        logic signed [63:0] rounded;
        logic               neg;
        int                 n;
        n = (cnt == 0) ? 1 : int'(cnt);
        if (n > gis_pkg::MAX_SEGMENTS)
            n = gis_pkg::MAX_SEGMENTS;
        r = (ratio_in <= RATIO_ONE[31:0]) ? RATIO_ONE : {32'd0, ratio_in};
        l64 = lft;
        r64 = rgt;
        span = r64 - l64;
        neg = span < 0;
        mag = neg ? -span : span;

        // geometric sum of ratio powers, both saturating
        pw = RATIO_ONE;
        total = '0;
        for (int k = 0; k < n; k++)
        begin
            total_wide = {1'b0, total} + {1'b0, pw};
            total = (total_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_wide[63:0];
            pw = grow(pw, r, POWER_MAX);
        end

        quot = ({64'd0, mag} << (30 + FRAC_X)) / {64'd0, total};
        step = quot[63:0];
        if (step < ({48'd0, zero_thr} << FRAC_X))
            step = '0;
        if (step > STEP_MAX)
            step = STEP_MAX;

        expected_nodes.push_back('{coord: lft, index: '0, last: 1'b0});
        pos = l64 <<< FRAC_X;
        for (int k = 1; k < n; k++)
        begin
            pos = neg ? pos - $signed(step) : pos + $signed(step);
            if (pos < POS_LO)
                pos = POS_LO;
            if (pos > POS_HI)
                pos = POS_HI;
            rounded = (pos + 64'sd32768) >>> FRAC_X;
            expected_nodes.push_back('{coord: rounded[31:0], index: 6'(k), last: 1'b0});
            step = grow(step, r, STEP_MAX);
        end
        expected_nodes.push_back('{coord: rgt, index: 6'(n), last: 1'b1});
    endtask

    task automatic check_node();
        node_t want;
        if (expected_nodes.size() == 0)
        begin
            report($sformatf("node with no interval pending: coord %0d index %0d",
                             node_coord, node_index));
        end
        else
        begin
            want = expected_nodes.pop_front();
            if (node_coord !== want.coord)
                report($sformatf("node %0d coord: got %0d want %0d",
                                 want.index, node_coord, want.coord));
            if (node_index !== want.index)
                report($sformatf("node index: got %0d want %0d", node_index, want.index));
            if (last_node !== want.last)
                report($sformatf("node %0d last flag: got %b want %b",
                                 want.index, last_node, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_thr = '0;
            expected_nodes.delete();
            owed = 0;
        end
        else
        begin
            if (in_valid === 1'b1 && in_ready === 1'b1)
                plan_nodes(left_coord, right_coord, segment_count, growth_ratio);
            if (out_valid === 1'b1 && out_ready === 1'b1)
                check_node();
            if (cfg_we === 1'b1)
                zero_thr = cfg_wdata;
            owed = expected_nodes.size();
        end
    end

endmodule

// File: sim/tb_graded_interval_subdivider_top.sv
// Testbench top for the graded interval subdivider: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_graded_interval_subdivider_top;

    localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX   = 32'sh7FFF_FFFF;
    localparam logic [31:0]        RATIO_ONE = 32'h4000_0000;
    localparam logic [31:0]        RATIO_MAX = 32'hFFFF_FFFF;
    localparam int                 ITEMS_PER_PHASE = 30;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [gis_pkg::THR_W-1:0] cfg_wdata;
    int                        fail_count;
    int                        nodes_owed;
    // remaining items of a no-idle stretch, one counter per side
    int                        send_burst = 0;
    int                        take_burst = 0;

    gis_in_if  interval_ch ();
    gis_out_if node_ch ();

    graded_interval_subdivider_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .interval  (interval_ch),
        .nodes     (node_ch)
    );

    // The checker only watches: it sees both handshakes and every register write,
    // keeps its own copy of the threshold and returns a failure count plus the
    // number of node items still owed by the block.
    gis_node_checker node_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (interval_ch.valid),
        .in_ready      (interval_ch.ready),
        .left_coord    (interval_ch.left_coord),
        .right_coord   (interval_ch.right_coord),
        .segment_count (interval_ch.segment_count),
        .growth_ratio  (interval_ch.growth_ratio),
        .out_valid     (node_ch.valid),
        .out_ready     (node_ch.ready),
        .node_coord    (node_ch.node_coord),
        .node_index    (node_ch.node_index),
        .last_node     (node_ch.last_node),
        .fail_count    (fail_count),
        .nodes_owed    (nodes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop. The slowest correct run (every interval at 63 segments, every node
    // behind the longest stall, every interval behind the longest gap) stays near 2 ms,
    // so this leaves plenty of margin.
    initial
    begin
        #15_000_000;
        $display("graded_interval_subdivider_top: mismatch");
        $finish;
    end

    // Draw the wait before one item: mostly a uniform random wait, sometimes a run of
    // back-to-back items so the block also sees full throughput on that side.
    function automatic int pick_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Present one interval and hold it until the block takes it. Called and
    // returning just after a falling edge; valid is left high so that a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_interval(input logic signed [31:0] lft, input logic signed [31:0] rgt,
                                 input logic [5:0] cnt, input logic [31:0] ratio);
        int gap;
        gap = pick_wait(send_burst);
        if (gap > 0)
        begin
            interval_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        interval_ch.left_coord    = lft;
        interval_ch.right_coord   = rgt;
        interval_ch.segment_count = cnt;
        interval_ch.growth_ratio  = ratio;
        interval_ch.valid         = 1'b1;
        do
            @(posedge clk);
        while (interval_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted node has come out.
    task automatic wait_all_nodes();
        interval_ch.valid = 1'b0;
        while (nodes_owed != 0)
            @(negedge clk);
    endtask

    // Write the step threshold; the block is idle once all nodes are out,
    // since every interval ends in its last node.
    task automatic write_threshold(input logic [gis_pkg::THR_W-1:0] value);
        wait_all_nodes();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random interval. Spans range from zero through short ones of up to 2000 LSBs (where the
    // threshold bites) to the full 33-bit range; counts are mostly small to keep the run short;
    // ratios cover uniform, barely graded, moderate and saturating growth.
    task automatic random_interval(output logic signed [31:0] lft,
                                   output logic signed [31:0] rgt,
                                   output logic [5:0] cnt, output logic [31:0] ratio);
        int delta;
        case ($urandom_range(0, 7))
            0:       lft = INT_MIN;
            1:       lft = INT_MAX;
            default: lft = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                rgt = $urandom;
            end
            4, 5, 6:
            begin
                delta = $urandom_range(0, 4000);
                rgt = lft + (delta - 2000);
            end
            7, 8:
            begin
                delta = $urandom_range(0, 200);
                rgt = lft - delta;
            end
            default:
            begin
                rgt = lft;
            end
        endcase
        case ($urandom_range(0, 19))
            0:       cnt = 6'd0;
            1:       cnt = 6'd63;
            2, 3, 4: cnt = 6'($urandom_range(9, 63));
            default: cnt = 6'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       ratio = $urandom_range(0, RATIO_ONE);
            1:       ratio = RATIO_ONE;
            2, 3, 4: ratio = RATIO_ONE + $urandom_range(1, 32'h0400_0000);
            5, 6:    ratio = $urandom_range(RATIO_ONE, 32'h8000_0000);
            7:       ratio = $urandom;
            8:       ratio = RATIO_MAX;
            default: ratio = $urandom_range(32'h8000_0000, RATIO_MAX);
        endcase
    endtask

    // Node side: take node items with a fresh random stall before each one.
    initial
    begin
        int stall;
        node_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = pick_wait(take_burst);
            if (stall > 0)
            begin
                node_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            node_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (node_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    // Interval side: directed corners, then random phases, each under its own threshold.
    initial
    begin
        logic signed [31:0]        lft;
        logic signed [31:0]        rgt;
        logic [5:0]                cnt;
        logic [31:0]               ratio;
        logic [gis_pkg::THR_W-1:0] thr_plan [5];

        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_wdata                 = '0;
        interval_ch.valid         = 1'b0;
        interval_ch.left_coord    = '0;
        interval_ch.right_coord   = '0;
        interval_ch.segment_count = '0;
        interval_ch.growth_ratio  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, threshold still at its reset value of zero.
        // single segment: only the two end nodes
        send_interval(32'sh0000_0000, 32'sh0001_0000, 6'd1, RATIO_ONE);
        // zero count behaves as one segment
        send_interval(-32'sd5, 32'sd7, 6'd0, RATIO_ONE);
        // widest span both ways at the largest count
        send_interval(INT_MIN, INT_MAX, 6'd63, RATIO_ONE);
        send_interval(INT_MAX, INT_MIN, 6'd63, RATIO_ONE);
        // ratio of zero and just below one: uniform spacing
        send_interval(32'sh0010_0000, 32'sh0050_0000, 6'd4, 32'h0000_0000);
        send_interval(-32'sh0003_0000, 32'sh0007_8000, 6'd7, RATIO_ONE - 1);
        // smallest graded ratio and a few ordinary ones
        send_interval(32'sh0000_0000, 32'sh0064_0000, 6'd10, RATIO_ONE + 1);
        send_interval(-32'sh0100_0000, 32'sh0200_0000, 6'd8, 32'h6000_0000);
        send_interval(32'sh0200_0000, -32'sh0100_0000, 6'd40, 32'h8000_0000);
        // huge ratio: powers, sum, increments and position all saturate
        send_interval(INT_MIN, INT_MAX, 6'd63, RATIO_MAX);
        send_interval(INT_MAX, INT_MIN, 6'd20, RATIO_MAX);
        send_interval(32'sh0000_1000, INT_MAX, 6'd63, 32'hC000_0000);
        // zero span and spans of a few LSBs, where rounding decides each node
        send_interval(32'sd1234, 32'sd1234, 6'd5, RATIO_ONE);
        send_interval(32'sd0, 32'sd3, 6'd63, RATIO_ONE);
        send_interval(-32'sd1, -32'sd4, 6'd6, 32'h5000_0000);
        // end points at the coordinate limits, one LSB apart
        send_interval(INT_MAX, INT_MAX - 1, 6'd2, RATIO_ONE);
        send_interval(INT_MIN, INT_MIN + 1, 6'd3, RATIO_MAX);

        // Random phases: largest threshold, smallest nonzero, random, back to zero,
        // and a small random one. Each write waits for the block to run dry.
        thr_plan[0] = 16'hFFFF;
        thr_plan[1] = 16'h0001;
        thr_plan[2] = 16'($urandom);
        thr_plan[3] = 16'h0000;
        thr_plan[4] = 16'($urandom_range(2, 255));
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thr_plan[ph]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // hold the sender once mid-phase until the node side is empty
                if (ph == 2 && i == ITEMS_PER_PHASE / 2)
                    wait_all_nodes();
                random_interval(lft, rgt, cnt, ratio);
                send_interval(lft, rgt, cnt, ratio);
            end
        end

        // Drain, then give stray nodes time to show up before the verdict.
        wait_all_nodes();
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("graded_interval_subdivider_top: match");
        else
            $display("graded_interval_subdivider_top: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gis_pkg.sv
rtl/gis_if.sv
rtl/gis_front.sv
rtl/gis_queue.sv
rtl/gis_back.sv
rtl/graded_interval_subdivider_top.sv
sim/gis_node_checker.sv
sim/tb_graded_interval_subdivider_top.sv
